// ----- rtl/mi3_pkg.sv -----
// shared types, widths and helpers for the 3x3 adjugate matrix inverse core
// no dependencies; every other file imports this package
package mi3_pkg;

  localparam int ELEM_W      = 32;
  localparam int NUM_EL      = 9;
  localparam int PROD_W      = 64;
  localparam int COF_W       = 65;
  localparam int MAG_W       = 64;
  localparam int TERM_W      = 96;
  localparam int DET_W       = 98;
  localparam int DABS_W      = 97;
  localparam int THR_W       = 17;
  localparam int Q_W         = 32;
  localparam int DIV_STEPS   = 32;
  localparam int COF_STAGES  = 2;
  localparam int DET_STAGES  = 5;
  localparam int DIV_FIRST   = COF_STAGES + DET_STAGES;
  localparam int NUM_STAGES  = DIV_FIRST + DIV_STEPS + 1;
  localparam int PADDR_W     = 3;

  // register map: word index taken from paddr bit 2
  localparam logic REG_ZERO_THR = 1'b0;
  localparam logic [THR_W-1:0] THR_RESET = 17'd1;

  // elements in port order: index c*3+r
  typedef logic [NUM_EL-1:0][ELEM_W-1:0] mat_t;

  // cofactors stored row major: index r*3+c
  typedef struct packed {
    logic [NUM_EL-1:0][COF_W-1:0] cof;
    mat_t                         mat;
  } cof_pkt_t;

  // division lanes in output port order
  typedef struct packed {
    logic [DABS_W-1:0]              dabs;
    logic [NUM_EL-1:0][DABS_W-1:0]  rem;
    logic [NUM_EL-1:0][Q_W-1:0]     quo;
    logic [NUM_EL-1:0]              neg;
    logic [NUM_EL-1:0]              ovf;
    logic                           singular;
    mat_t                           mat;
  } div_pkt_t;

  typedef struct packed {
    mat_t res;
    logic singular;
    logic saturated;
  } res_pkt_t;

  // element at row r, column c
  function automatic logic signed [ELEM_W-1:0] elem(mat_t m, int r, int c);
    return signed'(m[c*3+r]);
  endfunction

endpackage

// ----- rtl/mi3_cofactor.sv -----
// two pipeline stages: element products, then the nine cyclic cofactors
// depends on mi3_pkg
module mi3_cofactor
  import mi3_pkg::*;
(
  input  logic                  clk,
  input  logic [COF_STAGES-1:0] en,
  input  mat_t                  mat_in,
  output cof_pkt_t              pkt_out
);

  logic signed [PROD_W-1:0] pa_r [NUM_EL];
  logic signed [PROD_W-1:0] pb_r [NUM_EL];
  mat_t                     mat_r;
  cof_pkt_t                 pkt_r;

  // stage 1: the two products of each 2x2 minor
  always_ff @(posedge clk) begin
    if (en[0]) begin
      mat_r <= mat_in;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pa_r[r*3+c] <= PROD_W'(elem(mat_in, (r+1)%3, (c+1)%3))
                       * PROD_W'(elem(mat_in, (r+2)%3, (c+2)%3));
          pb_r[r*3+c] <= PROD_W'(elem(mat_in, (r+1)%3, (c+2)%3))
                       * PROD_W'(elem(mat_in, (r+2)%3, (c+1)%3));
        end
      end
    end
  end

  // stage 2: cofactor difference, sign comes from the cyclic form
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pkt_r.mat <= mat_r;
      for (int k = 0; k < NUM_EL; k++) begin
        pkt_r.cof[k] <= COF_W'(pa_r[k]) - COF_W'(pb_r[k]);
      end
    end
  end

  assign pkt_out = pkt_r;

endmodule

// ----- rtl/mi3_det.sv -----
// five pipeline stages: determinant, its magnitude, singular test, divider setup
// depends on mi3_pkg
module mi3_det
  import mi3_pkg::*;
(
  input  logic                  clk,
  input  logic [DET_STAGES-1:0] en,
  input  cof_pkt_t              pkt_in,
  input  logic [THR_W-1:0]      zero_thr,
  output div_pkt_t              pkt_out
);

  logic [MAG_W-1:0]          cm   [3];
  logic [ELEM_W-1:0]         em   [3];
  logic [2:0]                sg;
  logic [PROD_W-1:0]         pl_r [3];
  logic [PROD_W-1:0]         ph_r [3];
  logic [2:0]                sg_r;
  logic signed [DET_W-1:0]   t_r  [3];
  logic signed [DET_W-1:0]   det_r;
  logic                      dneg_r;
  logic [DABS_W-1:0]         dabs_r;
  cof_pkt_t                  pa_r, pb_r, pc_r, pd_r;
  div_pkt_t                  pkt_r;
  logic [TERM_W-1:0]         term [3];

  // magnitudes of the first row and of its cofactors
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cm[c] = pkt_in.cof[c][COF_W-1] ? MAG_W'(-pkt_in.cof[c]) : MAG_W'(pkt_in.cof[c]);
      em[c] = elem(pkt_in.mat, 0, c) < 0 ? ELEM_W'(-elem(pkt_in.mat, 0, c))
                                         : ELEM_W'(elem(pkt_in.mat, 0, c));
      sg[c] = pkt_in.cof[c][COF_W-1] ^ pkt_in.mat[c*3][ELEM_W-1];
    end
  end

  // stage 1: 32x32 partial products of each determinant term
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pa_r <= pkt_in;
      sg_r <= sg;
      for (int c = 0; c < 3; c++) begin
        pl_r[c] <= PROD_W'(cm[c][31:0]) * PROD_W'(em[c]);
        ph_r[c] <= PROD_W'(cm[c][63:32]) * PROD_W'(em[c]);
      end
    end
  end

  // stage 2: combine halves and apply sign
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      term[c] = (TERM_W'(ph_r[c]) << 32) + TERM_W'(pl_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pb_r <= pa_r;
      for (int c = 0; c < 3; c++) begin
        t_r[c] <= sg_r[c] ? -signed'(DET_W'(term[c])) : signed'(DET_W'(term[c]));
      end
    end
  end

  // stage 3: determinant sum
  always_ff @(posedge clk) begin
    if (en[2]) begin
      pc_r  <= pb_r;
      det_r <= t_r[0] + t_r[1] + t_r[2];
    end
  end

  // stage 4: determinant magnitude
  always_ff @(posedge clk) begin
    if (en[3]) begin
      pd_r   <= pc_r;
      dneg_r <= det_r[DET_W-1];
      dabs_r <= det_r[DET_W-1] ? DABS_W'(-det_r) : DABS_W'(det_r);
    end
  end

  // stage 5: singular test, per-lane sign, magnitude and overflow
  always_ff @(posedge clk) begin
    if (en[4]) begin
      pkt_r.mat      <= pd_r.mat;
      pkt_r.dabs     <= dabs_r;
      pkt_r.singular <= (dabs_r == '0) || (dabs_r < DABS_W'({zero_thr, 32'b0}));
      for (int i = 0; i < NUM_EL; i++) begin
        pkt_r.neg[i] <= pd_r.cof[i][COF_W-1] ^ dneg_r;
        pkt_r.quo[i] <= '0;
        if (pd_r.cof[i][COF_W-1]) begin
          pkt_r.rem[i] <= DABS_W'(MAG_W'(-pd_r.cof[i]));
          pkt_r.ovf[i] <= DABS_W'(MAG_W'(-pd_r.cof[i])) >= dabs_r;
        end else begin
          pkt_r.rem[i] <= DABS_W'(MAG_W'(pd_r.cof[i]));
          pkt_r.ovf[i] <= DABS_W'(MAG_W'(pd_r.cof[i])) >= dabs_r;
        end
      end
    end
  end

  assign pkt_out = pkt_r;

endmodule

// ----- rtl/mi3_div_step.sv -----
// one restoring division step for all nine lanes, one quotient bit each
// depends on mi3_pkg
module mi3_div_step
  import mi3_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  div_pkt_t pkt_in,
  output div_pkt_t pkt_out
);

  div_pkt_t pkt_nxt;
  div_pkt_t pkt_r;

  // shift in a zero dividend bit, subtract when it fits
  always_comb begin
    logic [DABS_W:0] t;
    logic            b;
    pkt_nxt = pkt_in;
    for (int i = 0; i < NUM_EL; i++) begin
      t = {pkt_in.rem[i], 1'b0};
      b = t >= {1'b0, pkt_in.dabs};
      pkt_nxt.rem[i] = b ? DABS_W'(t - {1'b0, pkt_in.dabs}) : DABS_W'(t);
      pkt_nxt.quo[i] = {pkt_in.quo[i][Q_W-2:0], b};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_out = pkt_r;

endmodule

// ----- rtl/mi3_round.sv -----
// output stage: round to nearest, saturate, or pass the matrix through
// depends on mi3_pkg
module mi3_round
  import mi3_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  div_pkt_t pkt_in,
  output res_pkt_t pkt_out
);

  localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

  res_pkt_t pkt_nxt;
  res_pkt_t pkt_r;

  // round half away from zero on magnitude, then clip
  always_comb begin
    logic            up;
    logic [Q_W:0]    q;
    logic [Q_W:0]    lim;
    logic            sat;
    logic            any_sat;
    any_sat = 1'b0;
    pkt_nxt = '0;
    for (int i = 0; i < NUM_EL; i++) begin
      up  = {pkt_in.rem[i], 1'b0} >= {1'b0, pkt_in.dabs};
      q   = {1'b0, pkt_in.quo[i]} + (Q_W+1)'(up);
      lim = pkt_in.neg[i] ? {1'b0, SAT_NEG} : {1'b0, SAT_POS};
      sat = pkt_in.ovf[i] || (q > lim);
      any_sat = any_sat | sat;
      if (sat) begin
        pkt_nxt.res[i] = pkt_in.neg[i] ? SAT_NEG : SAT_POS;
      end else begin
        pkt_nxt.res[i] = pkt_in.neg[i] ? Q_W'(-q) : q[Q_W-1:0];
      end
    end
    if (pkt_in.singular) begin
      pkt_nxt.res       = pkt_in.mat;
      pkt_nxt.singular  = 1'b1;
      pkt_nxt.saturated = 1'b0;
    end else begin
      pkt_nxt.singular  = 1'b0;
      pkt_nxt.saturated = any_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_out = pkt_r;

endmodule

// ----- rtl/matrix3_inverse_adjugate_core.sv -----
// 3x3 signed Q16.16 matrix inverse by cofactors over the determinant
// top level; depends on mi3_pkg, mi3_cofactor, mi3_det, mi3_div_step, mi3_round
//
// One matrix word enters per clock while in_ready is high, and its inverse
// leaves through the pipeline (2 cofactor stages, 5 determinant stages, 32
// restoring divide stages that run nine lanes side by side, 1 rounding/output
// stage). Throughput is one matrix per cycle; a stall on the output only backs
// up the pipeline as far as needed, empty stages keep filling. A matrix whose
// determinant magnitude is below zero_threshold (unsigned Q1.16, register at
// address 0, reset 1) or exactly zero comes back unchanged with singular set;
// otherwise each element is rounded to nearest (ties away from zero) and
// clipped, with saturated set when any element was clipped.
module matrix3_inverse_adjugate_core
  import mi3_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // input matrix word
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_r0c0,
  input  logic signed [31:0]  in_r1c0,
  input  logic signed [31:0]  in_r2c0,
  input  logic signed [31:0]  in_r0c1,
  input  logic signed [31:0]  in_r1c1,
  input  logic signed [31:0]  in_r2c1,
  input  logic signed [31:0]  in_r0c2,
  input  logic signed [31:0]  in_r1c2,
  input  logic signed [31:0]  in_r2c2,
  // result word
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_r0c0,
  output logic signed [31:0]  out_r1c0,
  output logic signed [31:0]  out_r2c0,
  output logic signed [31:0]  out_r0c1,
  output logic signed [31:0]  out_r1c1,
  output logic signed [31:0]  out_r2c1,
  output logic signed [31:0]  out_r0c2,
  output logic signed [31:0]  out_r1c2,
  output logic signed [31:0]  out_r2c2,
  output logic                out_singular,
  output logic                out_saturated,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [THR_W-1:0]      thr_r;
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] en;
  mat_t                  mat_in;
  cof_pkt_t              cof_pkt;
  div_pkt_t              div_pipe [DIV_STEPS+1];
  res_pkt_t              res_pkt;

  // threshold register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_ZERO_THR) begin
      thr_r <= cfg_pwdata[THR_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_ZERO_THR) ? 32'(thr_r) : '0;

  // stage advance: a stage loads when empty or when the next one moves
  assign en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
  for (genvar k = 0; k < NUM_STAGES-1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready = en[0];

  // valid bits travel with the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign mat_in = {in_r2c2, in_r1c2, in_r0c2, in_r2c1, in_r1c1, in_r0c1,
                   in_r2c0, in_r1c0, in_r0c0};

  mi3_cofactor u_cof (
    .clk     (clk),
    .en      (en[COF_STAGES-1:0]),
    .mat_in  (mat_in),
    .pkt_out (cof_pkt)
  );

  mi3_det u_det (
    .clk      (clk),
    .en       (en[DIV_FIRST-1:COF_STAGES]),
    .pkt_in   (cof_pkt),
    .zero_thr (thr_r),
    .pkt_out  (div_pipe[0])
  );

  // divide pipeline, one quotient bit per stage
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    mi3_div_step u_step (
      .clk     (clk),
      .en      (en[DIV_FIRST+s]),
      .pkt_in  (div_pipe[s]),
      .pkt_out (div_pipe[s+1])
    );
  end

  mi3_round u_round (
    .clk     (clk),
    .en      (en[NUM_STAGES-1]),
    .pkt_in  (div_pipe[DIV_STEPS]),
    .pkt_out (res_pkt)
  );

  assign out_valid     = v_r[NUM_STAGES-1];
  assign out_r0c0      = signed'(res_pkt.res[0]);
  assign out_r1c0      = signed'(res_pkt.res[1]);
  assign out_r2c0      = signed'(res_pkt.res[2]);
  assign out_r0c1      = signed'(res_pkt.res[3]);
  assign out_r1c1      = signed'(res_pkt.res[4]);
  assign out_r2c1      = signed'(res_pkt.res[5]);
  assign out_r0c2      = signed'(res_pkt.res[6]);
  assign out_r1c2      = signed'(res_pkt.res[7]);
  assign out_r2c2      = signed'(res_pkt.res[8]);
  assign out_singular  = res_pkt.singular;
  assign out_saturated = res_pkt.saturated;

endmodule
